// ===== rtl/per_key_token_bucket_limiter_core_assert.svh =====
// ----------------------------------------------------------------------------
// per_key_token_bucket_limiter_core_assert.svh
// assertion macros used by the limiter datapath rtl
// ----------------------------------------------------------------------------
`ifndef PER_KEY_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH
`define PER_KEY_TOKEN_BUCKET_LIMITER_CORE_ASSERT_SVH

// same-cycle implication
`define PKTBL_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PKTBL_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pktbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pktbl_pkg
// types and constants of the per-key token bucket limiter
// ----------------------------------------------------------------------------
package pktbl_pkg;

  localparam int FRAC_BITS = 24;
  localparam int TOK_BITS  = 40;
  localparam logic [TOK_BITS-1:0] ONE_TOK = 40'd1 << FRAC_BITS;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_INTERVAL = 3'd4;

  typedef struct packed {
    logic [63:0] flow_key;
    logic        key_empty;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [6:0] entries_in_use;
  } resp_t;

  typedef struct packed {
    logic start;
    logic bypass;
    logic insert;
    logic mul;
    logic upd;
    logic wb;
    logic sweep;
    logic evict;
    logic clear_oldest;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic scan_done;
    logic match;
    logic mod_done;
    logic mod_zero;
    logic over_cap;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/pktbl_rem.sv =====
// ----------------------------------------------------------------------------
// pktbl_rem
// bit-serial remainder of the call count by the cleanup interval
// ----------------------------------------------------------------------------
module pktbl_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic        zero
);

  logic        busy;
  logic [4:0]  n;
  logic [31:0] dv;
  logic [15:0] d;
  logic [15:0] rem;
  logic [16:0] sh;

  assign sh   = {rem, dv[31]};
  assign done = !busy;
  assign zero = (rem == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && n == 5'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= dividend;
      d   <= divisor;
      rem <= 16'd0;
      n   <= 5'd31;
    end else if (busy) begin
      // one restoring step per cycle
      if (sh >= {1'b0, d}) begin
        rem <= 16'(sh - {1'b0, d});
      end else begin
        rem <= sh[15:0];
      end
      dv <= {dv[30:0], 1'b0};
      n  <= n - 5'd1;
    end
  end

endmodule

// ===== rtl/pktbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pktbl_ctrl
// sequencer for lookup, refill, cleanup and eviction
// ----------------------------------------------------------------------------
module pktbl_ctrl
  import pktbl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_MUL, S_UPD, S_WB, S_MOD, S_SWEEP, S_CAP, S_EVICT, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.bypass) begin
            cmd.bypass = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.start  = 1'b1;
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (stat.scan_done) begin
          if (stat.match) begin
            state_next = S_MUL;
          end else begin
            cmd.insert = 1'b1;
            state_next = S_MOD;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (stat.mod_done) begin
          if (stat.mod_zero) begin
            cmd.sweep  = 1'b1;
            state_next = S_SWEEP;
          end else begin
            state_next = S_CAP;
          end
        end
      end
      S_SWEEP: begin
        if (stat.scan_done) begin
          state_next = S_CAP;
        end
      end
      S_CAP: begin
        if (stat.over_cap) begin
          cmd.evict  = 1'b1;
          state_next = S_EVICT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_EVICT: begin
        if (stat.scan_done) begin
          cmd.clear_oldest = 1'b1;
          state_next       = S_CAP;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/pktbl_dp.sv =====
// ----------------------------------------------------------------------------
// pktbl_dp
// bucket table, scan engine, refill arithmetic and result register
// ----------------------------------------------------------------------------
`include "per_key_token_bucket_limiter_core_assert.svh"

module pktbl_dp
  import pktbl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output resp_t                out_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = IW + 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {M_FIND, M_SWEEP, M_EVICT} scan_mode_t;

  // configuration
  logic [31:0] refill_rate;
  logic [15:0] burst_size;
  logic [31:0] idle_ticks;
  logic [6:0]  max_entries;
  logic [15:0] cleanup_interval;

  // current request
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_BITS-1:0] now_r;
  logic [31:0]          call_count;

  // table
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          count;
  logic [KEY_BITS-1:0]    key_mem [TABLE_DEPTH];
  logic [TOK_BITS-1:0]    tok_mem [TABLE_DEPTH];
  logic [TIME_BITS-1:0]   ref_mem [TABLE_DEPTH];
  logic [TIME_BITS-1:0]   act_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    key_q;
  logic [TOK_BITS-1:0]    tok_q;
  logic [TIME_BITS-1:0]   ref_q;
  logic [TIME_BITS-1:0]   act_q;
  logic                   v_q;

  // scan engine
  logic       active;
  scan_mode_t mode;
  logic [PW-1:0] cnt;
  logic          p_vld;
  logic [IW-1:0] p_idx;
  logic [IW-1:0] rd_addr;
  logic          issue;
  logic          scan_done;
  logic [TIME_BITS-1:0] age_q;

  // trackers
  logic                 m_found, f_found, o_found;
  logic [IW-1:0]        m_idx, f_idx, o_idx;
  logic [TOK_BITS-1:0]  m_tok;
  logic [TIME_BITS-1:0] m_ref;
  logic [TIME_BITS-1:0] o_age;

  // arithmetic
  logic [TIME_BITS-1:0] el;
  logic [63:0]          el64;
  logic                 el_zero, el_big;
  logic [63:0]          p_lo;
  logic [39:0]          p_hi;
  logic [71:0]          sum;
  logic [TOK_BITS-1:0]  room, t_new, spent, cap_tok;
  logic [15:0]          burst_eff;
  logic [6:0]           cap_eff;
  logic                 allowed_r, full;
  logic [IW-1:0]        ins_slot, wr_addr;
  logic                 wr_en;
  logic [TOK_BITS-1:0]  tok_wd;

  logic mod_done, mod_zero;

  assign burst_eff = (burst_size == 16'd0) ? 16'd1 : burst_size;
  assign cap_eff   = (max_entries == 7'd0) ? 7'd1 : max_entries;
  assign cap_tok   = {burst_eff, {FRAC_BITS{1'b0}}};
  assign full      = (count == CW'(TABLE_DEPTH));
  assign ins_slot  = full ? o_idx : f_idx;

  assign rd_addr   = cnt[IW-1:0];
  assign issue     = active && (cnt < PW'(TABLE_DEPTH));
  assign scan_done = active && (cnt == PW'(TABLE_DEPTH)) && !p_vld;
  assign age_q     = now_r - act_q;

  assign el   = now_r - m_ref;
  assign el64 = 64'(el);
  assign sum  = {8'b0, p_lo} + {p_hi, 32'b0};
  assign room = cap_tok - m_tok;
  assign spent = (t_new >= ONE_TOK) ? (t_new - ONE_TOK) : t_new;

  assign wr_en   = cmd.insert || cmd.wb;
  assign wr_addr = cmd.insert ? ins_slot : m_idx;
  assign tok_wd  = cmd.insert ? (cap_tok - ONE_TOK) : spent;

  assign stat.bypass    = (refill_rate == 32'd0) || in_data.key_empty;
  assign stat.scan_done = scan_done;
  assign stat.match     = m_found;
  assign stat.mod_done  = mod_done;
  assign stat.mod_zero  = mod_zero;
  assign stat.over_cap  = NW'(count) > NW'(cap_eff);
  assign stat.out_busy  = out_valid && out_stall;

  pktbl_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (call_count + 32'd1),
    .divisor  ((cleanup_interval == 16'd0) ? 16'd1 : cleanup_interval),
    .done     (mod_done),
    .zero     (mod_zero)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_rate      <= 32'd0;
      burst_size       <= 16'd1;
      idle_ticks       <= 32'd60000000;
      max_entries      <= 7'd64;
      cleanup_interval <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REFILL_RATE:      refill_rate      <= cfg_wdata;
        REG_BURST_SIZE:       burst_size       <= cfg_wdata[15:0];
        REG_IDLE_TICKS:       idle_ticks       <= cfg_wdata;
        REG_MAX_ENTRIES:      max_entries      <= cfg_wdata[6:0];
        REG_CLEANUP_INTERVAL: cleanup_interval <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // request latch and call counter
  always_ff @(posedge clk) begin
    if (rst) begin
      call_count <= 32'd0;
    end else if (cmd.start) begin
      call_count <= call_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_data.flow_key[KEY_BITS-1:0];
      now_r <= TIME_BITS'(in_data.timestamp);
    end
  end

  // memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      key_mem[ins_slot] <= key_r;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tok_mem[wr_addr] <= tok_wd;
      ref_mem[wr_addr] <= now_r;
      act_mem[wr_addr] <= now_r;
    end
    tok_q <= tok_mem[rd_addr];
    ref_q <= ref_mem[rd_addr];
    act_q <= act_mem[rd_addr];
    v_q   <= valid[rd_addr];
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      p_vld  <= 1'b0;
    end else begin
      if (cmd.start || cmd.sweep || cmd.evict) begin
        active <= 1'b1;
      end else if (scan_done) begin
        active <= 1'b0;
      end
      p_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.sweep || cmd.evict) begin
      cnt <= '0;
    end else if (issue) begin
      cnt <= cnt + PW'(1);
    end
    p_idx <= rd_addr;
    if (cmd.start) begin
      mode <= M_FIND;
    end else if (cmd.sweep) begin
      mode <= M_SWEEP;
    end else if (cmd.evict) begin
      mode <= M_EVICT;
    end
  end

  // match, first free and oldest trackers
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.evict) begin
      m_found <= 1'b0;
      f_found <= 1'b0;
      o_found <= 1'b0;
    end else if (p_vld && mode != M_SWEEP) begin
      if (mode == M_FIND && v_q && !m_found && key_q == key_r) begin
        m_found <= 1'b1;
        m_idx   <= p_idx;
        m_tok   <= tok_q;
        m_ref   <= ref_q;
      end
      if (mode == M_FIND && !v_q && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= p_idx;
      end
      // strict compare keeps the lowest index on ties
      if (v_q && (!o_found || age_q > o_age)) begin
        o_found <= 1'b1;
        o_idx   <= p_idx;
        o_age   <= age_q;
      end
    end
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.insert) begin
      valid[ins_slot] <= 1'b1;
      if (!full) begin
        count <= count + CW'(1);
      end
    end else if (cmd.clear_oldest) begin
      valid[o_idx] <= 1'b0;
      count        <= count - CW'(1);
    end else if (p_vld && mode == M_SWEEP && v_q && (64'(age_q) > 64'(idle_ticks))) begin
      valid[p_idx] <= 1'b0;
      count        <= count - CW'(1);
    end
  end

  // refill: elapsed * rate split into a 32x32 and an 8x32 product
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      el_zero <= (el == '0);
      el_big  <= |el64[63:40];
      p_lo    <= {32'b0, el64[31:0]} * {32'b0, refill_rate};
      p_hi    <= 40'(el64[39:32]) * 40'(refill_rate);
    end
    if (cmd.upd) begin
      if (el_zero) begin
        t_new <= m_tok;
      end else if (m_tok >= cap_tok) begin
        t_new <= cap_tok;
      end else if (el_big || sum > 72'(room)) begin
        t_new <= cap_tok;
      end else begin
        t_new <= m_tok + sum[TOK_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bypass || cmd.insert) begin
      allowed_r <= 1'b1;
    end else if (cmd.wb) begin
      allowed_r <= (t_new >= ONE_TOK);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.allowed        <= allowed_r;
      out_data.entries_in_use <= 7'(count);
    end
  end

  `PKTBL_ASSERT_IMP(a_count_tracks_valid, clk, rst, 1'b1,
    $countones(valid) == int'(count), "entry count differs from valid bits")
  `PKTBL_ASSERT_IMP(a_insert_has_slot, clk, rst, cmd.insert,
    (full ? o_found : f_found), "insert without a slot")
  `PKTBL_ASSERT_NXT(a_evict_drops_one, clk, rst, cmd.clear_oldest,
    count == CW'($past(count) - CW'(1)), "eviction did not drop one entry")
  `PKTBL_ASSERT_NXT(a_load_shows_result, clk, rst, cmd.load_out,
    out_valid, "loaded result not presented")

endmodule

// ===== rtl/per_key_token_bucket_limiter_core.sv =====
// ----------------------------------------------------------------------------
// per_key_token_bucket_limiter_core
// per-key token bucket rate limiter: lookup, refill, spend, cleanup, eviction
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in       | input     | in_valid / in_stall   | req_t  (flow_key, key_empty, timestamp)
//  out      | output    | out_valid / out_stall | resp_t (allowed, entries_in_use)
//  cfg      | input     | cfg_we                | cfg_index, cfg_wdata
//
//  a bypass transaction skips the table scan; a lookup scans the table
//  one entry per cycle through the table memory port, and a known key
//  then runs the refill steps S_MUL, S_UPD and S_WB
//  a cleanup sweep and each cap eviction add another full table scan
//  the interval remainder runs alongside the lookup scan
//  rst is synchronous; it clears valid bits, call count and registers, no
//  clearing pass; a new transaction is taken while a result waits on out_stall
// ----------------------------------------------------------------------------
module per_key_token_bucket_limiter_core
  import pktbl_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output resp_t                out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  pktbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, refill math and result register
  pktbl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
